/* rtl/wspp_pkg.sv */
// ----------------------------------------------------------------------------
// wspp_pkg: shared types and constants of the wheel speed controller
// Field widths, register indexes and reset values, micro-operation codes,
// jump conditions, the control word layout and the step addresses.
// ----------------------------------------------------------------------------
package wspp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SUM_WIDTH_DEF   = 24;

  localparam int ENC_W      = 32;
  localparam int TARGET_W   = 16;
  localparam int SPEED_W    = 16;
  localparam int DUTY_W     = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 15;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 4;

  localparam int SPEED_MAX = 32767;
  localparam int SPEED_MIN = -32768;
  localparam int DUTY_MAX  = 65535;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GAIN_PROP    = 3'd0;
  localparam cfg_idx_t CFG_GAIN_INTEG   = 3'd1;
  localparam cfg_idx_t CFG_GAIN_DERIV   = 3'd2;
  localparam cfg_idx_t CFG_DRIVE_LIMIT  = 3'd3;
  localparam cfg_idx_t CFG_SPEED_SCALE  = 3'd4;
  localparam cfg_idx_t CFG_DUTY_RECIP   = 3'd5;
  localparam cfg_idx_t CFG_COUNT_INVERT = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 24'd235930;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG  = 24'd17039;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV  = 24'd66;
  localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT = 15'd900;
  localparam logic [GAIN_W-1:0]  RST_SPEED_SCALE = 24'd103987;
  localparam logic [GAIN_W-1:0]  RST_DUTY_RECIP  = 24'd4772113;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [LIMIT_W-1:0] drive_limit;
    logic [GAIN_W-1:0]  speed_scale;
    logic [GAIN_W-1:0]  duty_recip;
    logic               count_invert;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DELTA,
    OP_SPEED_MUL,
    OP_ERROR,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_CLAMP,
    OP_MUL_DUTY,
    OP_OUT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_SKIP_TZ,
    COND_WAIT_OUT,
    COND_JUMP
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_DELTA = 4'd0;
  localparam step_t STEP_SPEED = 4'd1;
  localparam step_t STEP_ERROR = 4'd2;
  localparam step_t STEP_MUL_P = 4'd3;
  localparam step_t STEP_MUL_I = 4'd4;
  localparam step_t STEP_MUL_D = 4'd5;
  localparam step_t STEP_CLAMP = 4'd6;
  localparam step_t STEP_DUTY  = 4'd7;
  localparam step_t STEP_OUT   = 4'd8;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t jump;
  } ucode_t;

  typedef struct packed {
    uop_t op;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic target_zero;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/wspp_ucode_rom.sv */
// ----------------------------------------------------------------------------
// wspp_ucode_rom: control store of the controller program
// One control word per step: the datapath operation, the jump condition
// and the jump address.
// ----------------------------------------------------------------------------
module wspp_ucode_rom (
  input  wspp_pkg::step_t  step,
  output wspp_pkg::ucode_t word
);

  always_comb begin
    case (step)
      wspp_pkg::STEP_DELTA: begin
        word = '{wspp_pkg::OP_DELTA, wspp_pkg::COND_WAIT_IN, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_SPEED: begin
        word = '{wspp_pkg::OP_SPEED_MUL, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_ERROR: begin
        word = '{wspp_pkg::OP_ERROR, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_MUL_P: begin
        word = '{wspp_pkg::OP_MUL_P, wspp_pkg::COND_SKIP_TZ, wspp_pkg::STEP_CLAMP};
      end
      wspp_pkg::STEP_MUL_I: begin
        word = '{wspp_pkg::OP_MUL_I, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_MUL_D: begin
        word = '{wspp_pkg::OP_MUL_D, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_CLAMP: begin
        word = '{wspp_pkg::OP_CLAMP, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_DUTY: begin
        word = '{wspp_pkg::OP_MUL_DUTY, wspp_pkg::COND_NEXT, wspp_pkg::STEP_DELTA};
      end
      wspp_pkg::STEP_OUT: begin
        word = '{wspp_pkg::OP_OUT, wspp_pkg::COND_WAIT_OUT, wspp_pkg::STEP_DELTA};
      end
      default: begin
        word = '{wspp_pkg::OP_NOP, wspp_pkg::COND_JUMP, wspp_pkg::STEP_DELTA};
      end
    endcase
  end

endmodule

/* rtl/wspp_sequencer.sv */
// ----------------------------------------------------------------------------
// wspp_sequencer: step counter of the controller program
// Walks the control store, evaluates the jump condition of each word and
// tells the datapath which operation executes in this cycle.
// ----------------------------------------------------------------------------
module wspp_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  wspp_pkg::stat_t  stat,
  input  wspp_pkg::ucode_t word,
  output wspp_pkg::step_t  step,
  output wspp_pkg::ctrl_t  ctrl,
  output logic             in_ready
);

  wspp_pkg::step_t step_r;
  wspp_pkg::step_t step_nxt;
  logic            fire;

  always_comb begin
    fire     = 1'b1;
    step_nxt = step_r + wspp_pkg::step_t'(1);
    case (word.cond)
      wspp_pkg::COND_NEXT: begin
        fire     = 1'b1;
        step_nxt = step_r + wspp_pkg::step_t'(1);
      end
      wspp_pkg::COND_WAIT_IN: begin
        fire     = in_valid;
        step_nxt = in_valid ? step_r + wspp_pkg::step_t'(1) : step_r;
      end
      wspp_pkg::COND_SKIP_TZ: begin
        fire     = 1'b1;
        step_nxt = stat.target_zero ? word.jump : step_r + wspp_pkg::step_t'(1);
      end
      wspp_pkg::COND_WAIT_OUT: begin
        fire     = !stat.out_busy;
        step_nxt = stat.out_busy ? step_r : word.jump;
      end
      wspp_pkg::COND_JUMP: begin
        fire     = 1'b1;
        step_nxt = word.jump;
      end
      default: begin
        fire     = 1'b0;
        step_nxt = wspp_pkg::STEP_DELTA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= wspp_pkg::STEP_DELTA;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign step      = step_r;
  assign ctrl.op   = word.op;
  assign ctrl.fire = fire;
  assign in_ready  = (word.cond == wspp_pkg::COND_WAIT_IN);

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= wspp_pkg::STEP_OUT)
    else $error("step counter left the program");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == wspp_pkg::STEP_DELTA && !in_valid) |=> step_r == wspp_pkg::STEP_DELTA)
    else $error("program started without an input item");

  a_out_return: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && ctrl.op == wspp_pkg::OP_OUT) |=> step_r == wspp_pkg::STEP_DELTA)
    else $error("program did not return to the idle step");

endmodule

/* rtl/wspp_datapath.sv */
// ----------------------------------------------------------------------------
// wspp_datapath: shared multiplier, accumulator and controller state
// Executes one micro-operation per cycle when fired: count difference, speed
// scaling, error and integral update, PID products, clamp, duty mapping, output.
// ----------------------------------------------------------------------------
module wspp_datapath #(
  parameter int COUNT_WIDTH = wspp_pkg::COUNT_WIDTH_DEF,
  parameter int SUM_WIDTH   = wspp_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wspp_pkg::ctrl_t                     ctrl,
  input  wspp_pkg::cfg_t                      cfg,
  input  logic signed [wspp_pkg::ENC_W-1:0]   in_encoder_count,
  input  logic signed [wspp_pkg::TARGET_W-1:0] in_target_speed,
  input  logic                                out_ready,
  output wspp_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic [wspp_pkg::DUTY_W-1:0]         out_duty,
  output logic                                out_reverse,
  output logic signed [wspp_pkg::SPEED_W-1:0] out_measured_speed
);

  localparam int WIDE_W  = (COUNT_WIDTH > SUM_WIDTH) ? COUNT_WIDTH : SUM_WIDTH;
  localparam int MUL_A_W = (WIDE_W > wspp_pkg::DIFF_W) ? WIDE_W : wspp_pkg::DIFF_W;
  localparam int MUL_B_W = wspp_pkg::GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SACC_W  = SUM_WIDTH + 2;

  localparam logic signed [SACC_W-1:0] SUM_HI = {3'b000, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SACC_W-1:0] SUM_LO = {3'b111, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1 << (wspp_pkg::FRAC_W - 1));

  logic signed [COUNT_WIDTH-1:0]          last_count_r;
  logic signed [COUNT_WIDTH-1:0]          delta_r;
  logic signed [wspp_pkg::TARGET_W-1:0]   target_r;
  logic signed [wspp_pkg::SPEED_W-1:0]    speed_r;
  logic signed [wspp_pkg::ERR_W-1:0]      err_r;
  logic signed [wspp_pkg::ERR_W-1:0]      last_error_r;
  logic signed [wspp_pkg::DIFF_W-1:0]     diff_r;
  logic signed [SUM_WIDTH-1:0]            error_sum_r;
  logic [wspp_pkg::LIMIT_W-1:0]           mag_r;
  logic                                   dir_hold_r;
  logic signed [ACC_W-1:0]                acc_r;
  logic                                   out_valid_r;
  logic [wspp_pkg::DUTY_W-1:0]            out_duty_r;
  logic                                   out_reverse_r;
  logic signed [wspp_pkg::SPEED_W-1:0]    out_speed_r;

  logic [COUNT_WIDTH-1:0]                 cnt_raw;
  logic [COUNT_WIDTH-1:0]                 cnt;
  logic signed [MUL_A_W-1:0]              mul_a;
  logic signed [MUL_B_W-1:0]              mul_b;
  logic signed [PROD_W-1:0]               product;
  logic signed [ACC_W-1:0]                rnd;
  logic signed [wspp_pkg::SPEED_W-1:0]    speed_sat;
  logic signed [wspp_pkg::ERR_W-1:0]      err_new;
  logic signed [SACC_W-1:0]               sum_ext;
  logic signed [SUM_WIDTH-1:0]            sum_new;
  logic signed [wspp_pkg::DIFF_W-1:0]     diff_new;
  logic signed [ACC_W-1:0]                lim_pos;
  logic signed [ACC_W-1:0]                lim_neg;
  logic signed [ACC_W-1:0]                ctl;
  logic signed [ACC_W-1:0]                ctl_abs;
  logic [wspp_pkg::DUTY_W-1:0]            duty_sat;
  logic                                   fire_out;

  assign cnt_raw = in_encoder_count[COUNT_WIDTH-1:0];
  assign cnt     = cfg.count_invert ? (COUNT_WIDTH'(0) - cnt_raw) : cnt_raw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      wspp_pkg::OP_SPEED_MUL: begin
        mul_a = MUL_A_W'(delta_r);
        mul_b = $signed({1'b0, cfg.speed_scale});
      end
      wspp_pkg::OP_MUL_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed({1'b0, cfg.gain_prop});
      end
      wspp_pkg::OP_MUL_I: begin
        mul_a = MUL_A_W'(error_sum_r);
        mul_b = $signed({1'b0, cfg.gain_integ});
      end
      wspp_pkg::OP_MUL_D: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = $signed({1'b0, cfg.gain_deriv});
      end
      wspp_pkg::OP_MUL_DUTY: begin
        mul_a = MUL_A_W'($signed({1'b0, mag_r}));
        mul_b = $signed({1'b0, cfg.duty_recip});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign rnd     = acc_r >>> wspp_pkg::FRAC_W;

  always_comb begin
    if (rnd > ACC_W'(wspp_pkg::SPEED_MAX)) begin
      speed_sat = wspp_pkg::SPEED_W'(wspp_pkg::SPEED_MAX);
    end else if (rnd < ACC_W'(wspp_pkg::SPEED_MIN)) begin
      speed_sat = wspp_pkg::SPEED_W'(wspp_pkg::SPEED_MIN);
    end else begin
      speed_sat = rnd[wspp_pkg::SPEED_W-1:0];
    end
  end

  assign err_new  = wspp_pkg::ERR_W'(target_r) - wspp_pkg::ERR_W'(speed_sat);
  assign sum_ext  = SACC_W'(error_sum_r) + SACC_W'(err_new);
  assign diff_new = wspp_pkg::DIFF_W'(err_new) - wspp_pkg::DIFF_W'(last_error_r);

  always_comb begin
    if (sum_ext > SUM_HI) begin
      sum_new = SUM_HI[SUM_WIDTH-1:0];
    end else if (sum_ext < SUM_LO) begin
      sum_new = SUM_LO[SUM_WIDTH-1:0];
    end else begin
      sum_new = sum_ext[SUM_WIDTH-1:0];
    end
  end

  assign lim_pos = {{(ACC_W-wspp_pkg::LIMIT_W){1'b0}}, cfg.drive_limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (rnd > lim_pos) begin
      ctl = lim_pos;
    end else if (rnd < lim_neg) begin
      ctl = lim_neg;
    end else begin
      ctl = rnd;
    end
  end

  assign ctl_abs = ctl[ACC_W-1] ? -ctl : ctl;

  always_comb begin
    if (rnd > ACC_W'(wspp_pkg::DUTY_MAX)) begin
      duty_sat = wspp_pkg::DUTY_W'(wspp_pkg::DUTY_MAX);
    end else begin
      duty_sat = rnd[wspp_pkg::DUTY_W-1:0];
    end
  end

  assign fire_out = ctrl.fire && (ctrl.op == wspp_pkg::OP_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      last_error_r <= '0;
      error_sum_r  <= '0;
      dir_hold_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.fire) begin
        case (ctrl.op)
          wspp_pkg::OP_DELTA: begin
            last_count_r <= cnt;
          end
          wspp_pkg::OP_ERROR: begin
            last_error_r <= err_new;
            error_sum_r  <= stat.target_zero ? '0 : sum_new;
          end
          wspp_pkg::OP_CLAMP: begin
            if (ctl[ACC_W-1]) begin
              dir_hold_r <= 1'b1;
            end else if (ctl != '0) begin
              dir_hold_r <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        wspp_pkg::OP_DELTA: begin
          delta_r  <= cnt - last_count_r;
          target_r <= in_target_speed;
        end
        wspp_pkg::OP_SPEED_MUL: begin
          acc_r <= ACC_W'(product) + ROUND_BIAS;
        end
        wspp_pkg::OP_ERROR: begin
          speed_r <= speed_sat;
          err_r   <= err_new;
          diff_r  <= stat.target_zero ? '0 : diff_new;
        end
        wspp_pkg::OP_MUL_P: begin
          acc_r <= ACC_W'(product) + ROUND_BIAS;
        end
        wspp_pkg::OP_MUL_I: begin
          acc_r <= acc_r + ACC_W'(product);
        end
        wspp_pkg::OP_MUL_D: begin
          acc_r <= acc_r + ACC_W'(product);
        end
        wspp_pkg::OP_CLAMP: begin
          mag_r <= ctl_abs[wspp_pkg::LIMIT_W-1:0];
        end
        wspp_pkg::OP_MUL_DUTY: begin
          acc_r <= ACC_W'(product) + ROUND_BIAS;
        end
        wspp_pkg::OP_OUT: begin
          out_duty_r    <= duty_sat;
          out_reverse_r <= dir_hold_r;
          out_speed_r   <= speed_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.target_zero  = (target_r == '0);
  assign stat.out_busy     = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign out_duty           = out_duty_r;
  assign out_reverse        = out_reverse_r;
  assign out_measured_speed = out_speed_r;

  a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && ctrl.op == wspp_pkg::OP_CLAMP) |=> mag_r <= $past(cfg.drive_limit))
    else $error("clamped magnitude exceeds the drive limit");

  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && ctrl.op == wspp_pkg::OP_ERROR && stat.target_zero) |=> error_sum_r == '0)
    else $error("integral not cleared at zero target");

  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire_out |=> out_valid_r)
    else $error("result item not presented");

endmodule

/* rtl/wheel_speed_pid_pwm_top.sv */
// ----------------------------------------------------------------------------
// wheel_speed_pid_pwm_top: per-wheel speed controller with PWM duty output
// Each item carries a cumulative encoder count and a target speed. The block
// measures the wheel speed, runs PID on the speed error and returns the duty,
// the bridge direction and the measured speed as one result item.
//
// Input channel in_valid/in_ready, result channel out_valid/out_ready.
// Configuration writes use cfg_wr_en, cfg_index and cfg_wdata, one register
// per cycle; the user must see that they are made only while the block is
// idle, as the block itself does not enforce it. An item runs through a
// nine-step control program on one shared multiplier, and the next item is
// accepted only after the program has left its output step. The steps are
// the five multiplications in series plus the delta, error, clamp and output
// steps. The integral and derivative steps are skipped when the target is
// zero. While a result waits, the next item is accepted and processed; the
// program holds in its last step only if the receiver still has not taken
// the previous result. Reset restores the register defaults and clears the
// count history, error history, integral and held direction (forward).
// ----------------------------------------------------------------------------
module wheel_speed_pid_pwm_top #(
  parameter int COUNT_WIDTH = wspp_pkg::COUNT_WIDTH_DEF,
  parameter int SUM_WIDTH   = wspp_pkg::SUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wspp_pkg::ENC_W-1:0]    in_encoder_count,
  input  logic signed [wspp_pkg::TARGET_W-1:0] in_target_speed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wspp_pkg::DUTY_W-1:0]          out_duty,
  output logic                                 out_reverse,
  output logic signed [wspp_pkg::SPEED_W-1:0]  out_measured_speed,
  input  logic                                 cfg_wr_en,
  input  logic [wspp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wspp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  wspp_pkg::cfg_t   cfg_r;
  wspp_pkg::step_t  step;
  wspp_pkg::ucode_t word;
  wspp_pkg::ctrl_t  ctrl;
  wspp_pkg::stat_t  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop    <= wspp_pkg::RST_GAIN_PROP;
      cfg_r.gain_integ   <= wspp_pkg::RST_GAIN_INTEG;
      cfg_r.gain_deriv   <= wspp_pkg::RST_GAIN_DERIV;
      cfg_r.drive_limit  <= wspp_pkg::RST_DRIVE_LIMIT;
      cfg_r.speed_scale  <= wspp_pkg::RST_SPEED_SCALE;
      cfg_r.duty_recip   <= wspp_pkg::RST_DUTY_RECIP;
      cfg_r.count_invert <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wspp_pkg::CFG_GAIN_PROP: begin
          cfg_r.gain_prop <= cfg_wdata[wspp_pkg::GAIN_W-1:0];
        end
        wspp_pkg::CFG_GAIN_INTEG: begin
          cfg_r.gain_integ <= cfg_wdata[wspp_pkg::GAIN_W-1:0];
        end
        wspp_pkg::CFG_GAIN_DERIV: begin
          cfg_r.gain_deriv <= cfg_wdata[wspp_pkg::GAIN_W-1:0];
        end
        wspp_pkg::CFG_DRIVE_LIMIT: begin
          cfg_r.drive_limit <= cfg_wdata[wspp_pkg::LIMIT_W-1:0];
        end
        wspp_pkg::CFG_SPEED_SCALE: begin
          cfg_r.speed_scale <= cfg_wdata[wspp_pkg::GAIN_W-1:0];
        end
        wspp_pkg::CFG_DUTY_RECIP: begin
          cfg_r.duty_recip <= cfg_wdata[wspp_pkg::GAIN_W-1:0];
        end
        wspp_pkg::CFG_COUNT_INVERT: begin
          cfg_r.count_invert <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  wspp_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  wspp_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .word     (word),
    .step     (step),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  wspp_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .cfg                (cfg_r),
    .in_encoder_count   (in_encoder_count),
    .in_target_speed    (in_target_speed),
    .out_ready          (out_ready),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_duty           (out_duty),
    .out_reverse        (out_reverse),
    .out_measured_speed (out_measured_speed)
  );

endmodule

/* test/wheel_speed_pid_pwm_checker.sv */
// ----------------------------------------------------------------------------
// wheel_speed_pid_pwm_checker: result checker for the wheel speed controller
// Watches the input, result and register write ports of the block, keeps its
// own copy of the registers and of the controller state, works out the duty,
// direction and measured speed of every accepted item, and compares each
// accepted result with the oldest one still pending.
// ----------------------------------------------------------------------------
module wheel_speed_pid_pwm_checker #(
  parameter int COUNT_WIDTH = wspp_pkg::COUNT_WIDTH_DEF,
  parameter int SUM_WIDTH   = wspp_pkg::SUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [wspp_pkg::ENC_W-1:0]    in_encoder_count,
  input  logic signed [wspp_pkg::TARGET_W-1:0] in_target_speed,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [wspp_pkg::DUTY_W-1:0]          out_duty,
  input  logic                                 out_reverse,
  input  logic signed [wspp_pkg::SPEED_W-1:0]  out_measured_speed,
  input  logic                                 cfg_wr_en,
  input  logic [wspp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wspp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                   pending_count,
  output int                                   fail_count
);
  import wspp_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0]         duty;
    logic                      reverse;
    logic signed [SPEED_W-1:0] speed;
  } drive_t;

  logic [GAIN_W-1:0]  kp, ki, kd, scale, recip;
  logic [LIMIT_W-1:0] limit;
  logic               invert;

  logic [COUNT_WIDTH-1:0] prev_count;
  longint                 prev_error;
  longint                 error_integral;
  logic                   held_reverse;

  drive_t drive_q[$];
  int     mismatches = 0;

  function automatic longint round_q16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic drive_t predict_drive(input logic [ENC_W-1:0] enc,
                                           input logic signed [TARGET_W-1:0] tgt);
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] dcnt;
    longint delta, speed, err, diff, ctl, lim, mag, duty_l, sum_hi, sum_lo;
    drive_t res;
    sum_hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    sum_lo = -sum_hi - 1;
    cnt = enc[COUNT_WIDTH-1:0];
    if (invert) cnt = -cnt;
    dcnt = cnt - prev_count;
    prev_count = cnt;
    delta = longint'($signed(dcnt));
    speed = clip(round_q16(delta * longint'(scale)), SPEED_MIN, SPEED_MAX);
    err = longint'(tgt) - speed;
    error_integral = clip(error_integral + err, sum_lo, sum_hi);
    diff = err - prev_error;
    prev_error = err;
    if (tgt == 0) begin
      error_integral = 0;
      diff = 0;
    end
    ctl = round_q16(err * longint'(kp) + error_integral * longint'(ki)
                    + diff * longint'(kd));
    lim = longint'(limit);
    ctl = clip(ctl, -lim, lim);
    if (ctl > 0) held_reverse = 1'b0;
    else if (ctl < 0) held_reverse = 1'b1;
    mag = (ctl < 0) ? -ctl : ctl;
    duty_l = round_q16(mag * longint'(recip));
    if (duty_l > DUTY_MAX) duty_l = DUTY_MAX;
    res.duty    = duty_l[DUTY_W-1:0];
    res.reverse = held_reverse;
    res.speed   = speed[SPEED_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    drive_t got;
    drive_t want;
    if (!rst_n) begin
      kp             = RST_GAIN_PROP;
      ki             = RST_GAIN_INTEG;
      kd             = RST_GAIN_DERIV;
      limit          = RST_DRIVE_LIMIT;
      scale          = RST_SPEED_SCALE;
      recip          = RST_DUTY_RECIP;
      invert         = 1'b0;
      prev_count     = '0;
      prev_error     = 0;
      error_integral = 0;
      held_reverse   = 1'b0;
      drive_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GAIN_PROP:    kp     = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_INTEG:   ki     = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_DERIV:   kd     = cfg_wdata[GAIN_W-1:0];
          CFG_DRIVE_LIMIT:  limit  = cfg_wdata[LIMIT_W-1:0];
          CFG_SPEED_SCALE:  scale  = cfg_wdata[GAIN_W-1:0];
          CFG_DUTY_RECIP:   recip  = cfg_wdata[GAIN_W-1:0];
          CFG_COUNT_INVERT: invert = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.duty    = out_duty;
        got.reverse = out_reverse;
        got.speed   = out_measured_speed;
        if (drive_q.size() == 0) begin
          $display("%0t: result with no item pending: duty %0d reverse %0d speed %0d",
                   $time, got.duty, got.reverse, got.speed);
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          if (got.duty !== want.duty) begin
            $display("%0t: duty expected %0d, got %0d", $time, want.duty, got.duty);
            mismatches++;
          end
          if (got.reverse !== want.reverse) begin
            $display("%0t: reverse expected %0d, got %0d", $time, want.reverse,
                     got.reverse);
            mismatches++;
          end
          if (got.speed !== want.speed) begin
            $display("%0t: measured speed expected %0d, got %0d", $time, want.speed,
                     got.speed);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        drive_q.push_back(predict_drive(in_encoder_count, in_target_speed));
    end
    pending_count <= drive_q.size();
    fail_count    <= mismatches;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: regression for the wheel speed PID and PWM controller
// Drives encoder counts and target speeds in bursts with random gaps while
// the result side stalls on its own pattern. A directed set covers the field
// extremes, zero target, zero output, counter wrap and a zero drive limit;
// an integral wind-up phase saturates the integral both ways; random phases
// then run walking encoder counts under many register settings.
// ----------------------------------------------------------------------------
module testbench;
  import wspp_pkg::*;

  localparam int TICK_TARGET    = 850;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 12;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [ENC_W-1:0]    in_encoder_count = '0;
  logic signed [TARGET_W-1:0] in_target_speed = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic [DUTY_W-1:0]          out_duty;
  logic                       out_reverse;
  logic signed [SPEED_W-1:0]  out_measured_speed;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  int pending_count;
  int fail_count;
  int idle_cycles = 0;
  int ticks_sent = 0;
  int burst_left = 0;
  bit long_hold_req = 1'b0;

  wheel_speed_pid_pwm_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_encoder_count  (in_encoder_count),
    .in_target_speed   (in_target_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_reverse       (out_reverse),
    .out_measured_speed(out_measured_speed),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  wheel_speed_pid_pwm_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_encoder_count  (in_encoder_count),
    .in_target_speed   (in_target_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_reverse       (out_reverse),
    .out_measured_speed(out_measured_speed),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .pending_count     (pending_count),
    .fail_count        (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : sink
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        if (long_hold_req) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold_req = 1'b0;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic push_tick(input logic [ENC_W-1:0] enc, input logic [TARGET_W-1:0] tgt);
    int gap;
    in_valid         <= 1'b1;
    in_encoder_count <= enc;
    in_target_speed  <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] gp, gi, gd, lim, scale,
                              recip, inv);
    put_reg(CFG_GAIN_PROP, gp);
    put_reg(CFG_GAIN_INTEG, gi);
    put_reg(CFG_GAIN_DERIV, gd);
    put_reg(CFG_DRIVE_LIMIT, lim);
    put_reg(CFG_SPEED_SCALE, scale);
    put_reg(CFG_DUTY_RECIP, recip);
    put_reg(CFG_COUNT_INVERT, inv);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int profile;
    int phase_len;
    int span;
    int step;
    int sel;
    int t;
    longint r;
    logic [CFG_DATA_W-1:0] gp, gi, gd, lim, scale, recip, inv;
    logic [ENC_W-1:0] walk;
    logic [TARGET_W-1:0] setpoint;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset register values.
    push_tick(32'h0000_0000, 16'h0000);
    push_tick(32'd100, 16'h7FFF);
    push_tick(32'd200, 16'h8000);
    push_tick(32'd200, 16'h0000);
    push_tick(32'h7FFF_FFFF, 16'd1000);
    push_tick(32'h8000_0000, 16'd1000);
    push_tick(32'h7FFF_EC78, -16'sd1000);
    push_tick(32'hFFFF_FFFF, 16'h0000);
    push_tick(32'h0000_0010, 16'd25);
    walk = 32'h0000_0010;
    repeat (5) begin
      walk = walk + 30;
      push_tick(walk, 16'd300);
    end
    push_tick(32'h5555_5555, 16'h5555);
    push_tick(32'hAAAA_AAAA, 16'hAAAA);
    push_tick(32'hAAAA_AAAA, 16'hFFFF);
    settle();

    // Mirrored wheel with a zero drive limit.
    program_regs(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, 24'd0, RST_SPEED_SCALE,
                 RST_DUTY_RECIP, 24'd1);
    push_tick(32'd1000, 16'd500);
    push_tick(32'd2000, -16'sd500);
    push_tick(32'd2500, 16'h0000);
    push_tick(32'd2500, 16'd800);
    settle();

    // Integral wind-up to both rails, with the result side held off at first.
    program_regs(24'h01_0000, 24'h00_0100, 24'd0, 24'h7FFF, 24'hFF_FFFF, 24'h02_0000,
                 24'd0);
    long_hold_req = 1'b1;
    walk = 32'd0;
    repeat (140) begin
      walk = walk + 1000;
      push_tick(walk, 16'h8000);
    end
    push_tick(walk, 16'h0000);
    repeat (140) begin
      walk = walk - 1000;
      push_tick(walk, 16'h7FFF);
    end
    settle();

    while (ticks_sent < TICK_TARGET) begin
      profile = $urandom_range(0, 99);
      if (profile < 50) begin
        gp    = 24'($urandom_range(100000, 400000));
        gi    = 24'($urandom_range(0, 60000));
        gd    = 24'($urandom_range(0, 2000));
        lim   = 24'($urandom_range(200, 3000));
        scale = 24'($urandom_range(50000, 200000));
        r     = (longint'(65535) * 65536) / lim;
        recip = (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[CFG_DATA_W-1:0];
        inv   = 24'($urandom_range(0, 1));
      end else if (profile < 75) begin
        gp    = 24'($urandom());
        gi    = 24'($urandom());
        gd    = 24'($urandom());
        lim   = 24'($urandom());
        if (lim[LIMIT_W-1:0] == 0) lim[0] = 1'b1;
        scale = 24'($urandom());
        recip = 24'($urandom());
        inv   = 24'($urandom());
      end else if (profile < 87) begin
        gp    = 24'hFF_FFFF;
        gi    = 24'hFF_FFFF;
        gd    = 24'hFF_FFFF;
        lim   = 24'h00_7FFF;
        scale = 24'hFF_FFFF;
        recip = 24'hFF_FFFF;
        inv   = 24'($urandom_range(0, 1));
      end else begin
        gp    = 24'd0;
        gi    = 24'd0;
        gd    = 24'd0;
        lim   = 24'd1;
        scale = $urandom_range(0, 1) ? 24'd0 : 24'hFF_FFFF;
        recip = $urandom_range(0, 1) ? 24'd0 : 24'hFF_FFFF;
        inv   = 24'($urandom_range(0, 1));
      end
      program_regs(gp, gi, gd, lim, scale, recip, inv);

      phase_len = $urandom_range(30, 90);
      span      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200000)
                                              : $urandom_range(0, 3000);
      t         = $urandom_range(0, 4000);
      setpoint  = 16'(t - 2000);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: begin
              t = $urandom_range(0, 4000);
              setpoint = 16'(t - 2000);
            end
            1: setpoint = 16'($urandom());
            2: setpoint = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: setpoint = 16'h0000;
          endcase
        end
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          step = $urandom_range(0, 2 * span);
          walk = walk + (step - span);
        end else if (sel < 93) begin
          walk = $urandom();
        end else begin
          walk = walk + 32'h7FFF_FF00 + $urandom_range(0, 511);
        end
        push_tick(walk, ($urandom_range(0, 9) == 0) ? 16'h0000 : setpoint);
      end
      settle();
    end

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wspp_pkg.sv
rtl/wspp_ucode_rom.sv
rtl/wspp_sequencer.sv
rtl/wspp_datapath.sv
rtl/wheel_speed_pid_pwm_top.sv
test/wheel_speed_pid_pwm_checker.sv
test/testbench.sv
